@@ design/smrr_pkg.sv @@
// smrr_pkg: shared types and constants for the ranged SplitMix64 generator.
// Used by smrr_mul, smrr_div and splitmix_ranged_random_top; no dependencies.

package smrr_pkg;

    localparam int unsigned WORD_W = 64;

    typedef logic [WORD_W-1:0] word_t;

    // Counter increment and finaliser multipliers
    localparam word_t GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam word_t MIX_MUL_ONE = 64'hBF58_476D_1CE4_E5B9;
    localparam word_t MIX_MUL_TWO = 64'h94D0_49BB_1331_11EB;

    // Finaliser shift amounts
    localparam int unsigned MIX_SHIFT_ONE   = 30;
    localparam int unsigned MIX_SHIFT_TWO   = 27;
    localparam int unsigned MIX_SHIFT_THREE = 31;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_MUL1,
        S_WAIT1,
        S_MUL2,
        S_WAIT2,
        S_DIV,
        S_WAIT_DIV,
        S_DONE
    } state_t;

endpackage

@@ design/smrr_mul.sv @@
// smrr_mul: iterative 64 x 64 multiplier keeping the low 64 product bits.
// One 16-bit digit of the multiplier per cycle; depends on smrr_pkg.

module smrr_mul
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  smrr_pkg::word_t multiplicand,
    input  smrr_pkg::word_t multiplier,
    output logic           done,
    output smrr_pkg::word_t product
);

    localparam int unsigned DIGIT_W = 16;
    localparam int unsigned STEPS   = smrr_pkg::WORD_W / DIGIT_W;
    localparam int unsigned CNT_W   = $clog2(STEPS);

    smrr_pkg::word_t mcand_reg;
    smrr_pkg::word_t mplier_reg;
    smrr_pkg::word_t acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [smrr_pkg::WORD_W+DIGIT_W-1:0] partial;

    always_comb
    begin
        partial = mcand_reg * mplier_reg[DIGIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the operands one digit per cycle and accumulate the low word
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= multiplicand;
            mplier_reg <= multiplier;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_reg + partial[smrr_pkg::WORD_W-1:0];
            mcand_reg  <= mcand_reg << DIGIT_W;
            mplier_reg <= mplier_reg >> DIGIT_W;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ design/smrr_div.sv @@
// smrr_div: restoring divider, one quotient bit per cycle, remainder only.
// Depends on smrr_pkg for the word width.

module smrr_div
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  smrr_pkg::word_t dividend,
    input  smrr_pkg::word_t divisor,
    output logic           done,
    output smrr_pkg::word_t remainder
);

    localparam int unsigned W     = smrr_pkg::WORD_W;
    localparam int unsigned CNT_W = $clog2(W);

    smrr_pkg::word_t  dvd_reg;
    smrr_pkg::word_t  dsr_reg;
    smrr_pkg::word_t  rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0] rem_shift;
    logic [W:0] rem_diff;
    logic       fits;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        fits      = (rem_shift >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder stays below the divisor, so it fits in one word
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= fits ? rem_diff[W-1:0] : rem_shift[W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ design/splitmix_ranged_random_top.sv @@
// splitmix_ranged_random_top: SplitMix64 generator returning a value in a signed range.
// Depends on smrr_pkg, smrr_mul (finaliser multiplies) and smrr_div (range reduction).
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ------------------------
//  request   in         in_valid / in_stall     bound_a, bound_b (s64)
//  result    out        out_valid / out_stall   value (s64)
//  seed      in         seed_wr_en              seed (u64)
//
// A request with equal bounds goes from S_IDLE straight to S_DONE with bound_a as its result.
// Any other request runs S_STEP, two multiplies (4 digit steps each in smrr_mul),
// then a remainder (64 bit steps in smrr_div) from S_DIV and S_WAIT_DIV, then S_DONE.
// A full 64-bit span skips the divider and goes from S_DIV straight to S_DONE.
// The block takes one request at a time; in_stall is high from acceptance until
// the result moves into the output register, which may still hold an earlier
// result waiting on out_stall. The next request is taken in the cycle after that move.
// Reset clears the generator counter to zero.
// Write the seed only while the block is idle; it loads the counter at once.

module splitmix_ranged_random_top
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [63:0] bound_a,
    input  logic signed [63:0] bound_b,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] value,

    input  logic               seed_wr_en,
    input  logic        [63:0] seed
);

    smrr_pkg::state_t state_reg;
    smrr_pkg::state_t state_next;

    smrr_pkg::word_t counter_reg;   // generator counter
    smrr_pkg::word_t lo_reg;        // ordered bounds
    smrr_pkg::word_t hi_reg;
    smrr_pkg::word_t span_reg;      // hi - lo + 1, modulo 2^64
    smrr_pkg::word_t z_reg;         // finaliser working word
    smrr_pkg::word_t result_reg;    // finished result before the output stage
    smrr_pkg::word_t value_reg;     // output register
    logic            out_valid_reg;

    logic            in_fire;
    logic            bounds_equal;
    logic            bounds_swap;
    logic            out_load;

    logic            mul_start;
    smrr_pkg::word_t mul_a;
    smrr_pkg::word_t mul_b;
    logic            mul_done;
    smrr_pkg::word_t mul_product;

    logic            div_start;
    logic            div_done;
    smrr_pkg::word_t div_remainder;

    smrr_mul u_mul
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (mul_a),
        .multiplier   (mul_b),
        .done         (mul_done),
        .product      (mul_product)
    );

    smrr_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (z_reg),
        .divisor   (span_reg),
        .done      (div_done),
        .remainder (div_remainder)
    );

    assign in_fire      = in_valid && !in_stall;
    assign bounds_equal = (bound_a == bound_b);
    assign bounds_swap  = (bound_b < bound_a);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smrr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bounds_equal ? smrr_pkg::S_DONE : smrr_pkg::S_STEP;
                end
            end
            smrr_pkg::S_STEP:  state_next = smrr_pkg::S_MUL1;
            smrr_pkg::S_MUL1:  state_next = smrr_pkg::S_WAIT1;
            smrr_pkg::S_WAIT1:
            begin
                if (mul_done)
                begin
                    state_next = smrr_pkg::S_MUL2;
                end
            end
            smrr_pkg::S_MUL2:  state_next = smrr_pkg::S_WAIT2;
            smrr_pkg::S_WAIT2:
            begin
                if (mul_done)
                begin
                    state_next = smrr_pkg::S_DIV;
                end
            end
            smrr_pkg::S_DIV:
            begin
                state_next = (span_reg == '0) ? smrr_pkg::S_DONE : smrr_pkg::S_WAIT_DIV;
            end
            smrr_pkg::S_WAIT_DIV:
            begin
                if (div_done)
                begin
                    state_next = smrr_pkg::S_DONE;
                end
            end
            smrr_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = smrr_pkg::S_IDLE;
                end
            end
            default: state_next = smrr_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, unit starts and multiplier operands
    always_comb
    begin
        in_stall  = 1'b1;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        mul_a     = z_reg ^ (z_reg >> smrr_pkg::MIX_SHIFT_TWO);
        mul_b     = smrr_pkg::MIX_MUL_TWO;
        unique case (state_reg)
            smrr_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
            end
            smrr_pkg::S_MUL1:
            begin
                mul_start = 1'b1;
                mul_a     = counter_reg ^ (counter_reg >> smrr_pkg::MIX_SHIFT_ONE);
                mul_b     = smrr_pkg::MIX_MUL_ONE;
            end
            smrr_pkg::S_MUL2:
            begin
                mul_start = 1'b1;
            end
            smrr_pkg::S_DIV:
            begin
                div_start = (span_reg != '0);
            end
            smrr_pkg::S_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Control state: sequencer, generator counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smrr_pkg::S_IDLE;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Load the counter on a seed write, advance it once per mixed request
            if (seed_wr_en)
            begin
                counter_reg <= seed;
            end
            else if (state_reg == smrr_pkg::S_STEP)
            begin
                counter_reg <= counter_reg + smrr_pkg::GOLDEN_STEP;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath words
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            // Order the bounds by signed compare; equal bounds finish at once
            lo_reg     <= bounds_swap ? bound_b : bound_a;
            hi_reg     <= bounds_swap ? bound_a : bound_b;
            result_reg <= bound_a;
        end

        if (state_reg == smrr_pkg::S_MUL1)
        begin
            span_reg <= hi_reg - lo_reg + 64'd1;
        end

        if ((state_reg == smrr_pkg::S_WAIT1) && mul_done)
        begin
            z_reg <= mul_product;
        end

        if ((state_reg == smrr_pkg::S_WAIT2) && mul_done)
        begin
            z_reg <= mul_product ^ (mul_product >> smrr_pkg::MIX_SHIFT_THREE);
        end

        // Full 64-bit span: hand back the raw mixed word
        if ((state_reg == smrr_pkg::S_DIV) && (span_reg == '0))
        begin
            result_reg <= z_reg;
        end

        if ((state_reg == smrr_pkg::S_WAIT_DIV) && div_done)
        begin
            result_reg <= lo_reg + div_remainder;
        end

        if (out_load)
        begin
            value_reg <= result_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule
